// File: rtl/ppi_pkg.sv
// ----------------------------------------------------------------------------
// ppi_pkg: shared types, constants and tables for the particle pool integrator
// Q16.16 helpers, particle record layout, sequencer codes.
// ----------------------------------------------------------------------------
package ppi_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic CMD_EMIT   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
  localparam logic [30:0]        AGE_MAX = 31'h7FFF_FFFF;
  localparam logic [15:0]        N_LIMIT = 16'd12;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] drag;
    logic signed [31:0] angle;
    logic signed [31:0] spin;
    logic [30:0]        age;
    logic signed [31:0] life;
  } rec_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_LD, ST_OP, ST_WB, ST_ORD, ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_DT_DRAG, OP_INTERP, OP_FAC, OP_VX_ACC, OP_VY_ACC,
    OP_VX_DAMP, OP_VY_DAMP, OP_PX, OP_PY, OP_ANG
  } op_t;

  function automatic logic signed [31:0] qadd(logic signed [31:0] a,
                                               logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? Q_MIN : Q_MAX;
    return s[31:0];
  endfunction

  // exp(-k/16) * 65536
  function automatic logic [16:0] frac_lut(logic [4:0] k);
    case (k)
      5'd0:  return 17'd65536;
      5'd1:  return 17'd61565;
      5'd2:  return 17'd57835;
      5'd3:  return 17'd54331;
      5'd4:  return 17'd51039;
      5'd5:  return 17'd47947;
      5'd6:  return 17'd45042;
      5'd7:  return 17'd42313;
      5'd8:  return 17'd39750;
      5'd9:  return 17'd37341;
      5'd10: return 17'd35079;
      5'd11: return 17'd32954;
      5'd12: return 17'd30957;
      5'd13: return 17'd29081;
      5'd14: return 17'd27319;
      5'd15: return 17'd25664;
      5'd16: return 17'd24109;
      default: return 17'd0;
    endcase
  endfunction

  // exp(-n) * 65536
  function automatic logic [16:0] whole_lut(logic [3:0] n);
    case (n)
      4'd0:  return 17'd65536;
      4'd1:  return 17'd24109;
      4'd2:  return 17'd8869;
      4'd3:  return 17'd3263;
      4'd4:  return 17'd1200;
      4'd5:  return 17'd442;
      4'd6:  return 17'd162;
      4'd7:  return 17'd60;
      4'd8:  return 17'd22;
      4'd9:  return 17'd8;
      4'd10: return 17'd3;
      4'd11: return 17'd1;
      default: return 17'd0;
    endcase
  endfunction

endpackage

// File: rtl/particle_pool_integrator.sv
// ----------------------------------------------------------------------------
// particle_pool_integrator: particle pool with Euler integration and drag
// Stores particles and advances them through one shared Q16.16 multiplier.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Command emit stores
// one particle at the end of the pool when it is not full and in_time_value
// is positive, and gives one result the cycle after the request, with
// out_accepted high if stored; the block never goes busy for it. Command
// update advances every stored particle, drops the expired ones while
// keeping order, then reports each survivor in order, out_last on the final
// one; with no survivor one empty result is given. Each result is on the
// out_ ports for one cycle with out_valid high; the receiver cannot stall.
// out_live_count is the pool size afterwards. Update: for each stored
// particle read, load, ten multiplies in the shared multiplier and write
// back, then each survivor is read back out of the record memory.
// Reset empties the pool; memory contents are not cleared.
// ----------------------------------------------------------------------------
module particle_pool_integrator
  import ppi_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_command,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_acc_x,
  input  logic signed [31:0] in_acc_y,
  input  logic signed [31:0] in_drag_rate,
  input  logic signed [31:0] in_angle,
  input  logic signed [31:0] in_spin,
  input  logic [30:0]        in_start_age,
  input  logic signed [31:0] in_time_value,
  output logic               out_valid,
  output logic               out_accepted,
  output logic               out_particle_valid,
  output logic               out_last,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic signed [31:0] out_angle,
  output logic [30:0]        out_age,
  output logic [6:0]         out_live_count
);

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   ph_r, ph_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, kept_r, kept_nxt, occ_r, occ_nxt;
  logic signed [31:0] dt_r, dt_nxt, x_r, x_nxt, e_r, e_nxt, fac_r, fac_nxt;
  rec_t w_r, w_nxt;

  logic ov_r, ov_nxt, oacc_r, oacc_nxt, opv_r, opv_nxt, olast_r, olast_nxt;
  rec_t orec_r, orec_nxt;
  logic [CNT_W-1:0] olive_r, olive_nxt;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  rec_t             mem_wdata, mem_rdata;
  logic signed [31:0] mul_a, mul_b, mul_q;

  logic [CNT_W-1:0] i_inc, kept_inc;
  logic             alive, n_big;
  logic [31:0]      age_sum;
  logic [16:0]      frac_lo, frac_hi;

  ppi_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ppi_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .q    (mul_q)
  );

  assign i_inc    = CNT_W'(i_r + 1'b1);
  assign kept_inc = CNT_W'(kept_r + 1'b1);
  assign alive    = $signed({2'b00, w_r.age}) < $signed({w_r.life[31], w_r.life});
  assign n_big    = x_r[31:16] >= N_LIMIT;
  assign age_sum  = {1'b0, mem_rdata.age} + {1'b0, dt_r[30:0]};
  assign frac_hi  = frac_lut({1'b0, x_r[15:12]});
  assign frac_lo  = frac_lut(5'({1'b0, x_r[15:12]} + 5'd1));

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    ph_nxt    = ph_r;
    i_nxt     = i_r;
    kept_nxt  = kept_r;
    occ_nxt   = occ_r;
    dt_nxt    = dt_r;
    x_nxt     = x_r;
    e_nxt     = e_r;
    fac_nxt   = fac_r;
    w_nxt     = w_r;
    ov_nxt    = 1'b0;
    oacc_nxt  = oacc_r;
    opv_nxt   = opv_r;
    olast_nxt = olast_r;
    orec_nxt  = orec_r;
    olive_nxt = olive_r;
    mem_we    = 1'b0;
    mem_waddr = kept_r[IDX_W-1:0];
    mem_wdata = w_r;
    mem_raddr = i_r[IDX_W-1:0];
    mul_a     = '0;
    mul_b     = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_command == CMD_EMIT) begin
            ov_nxt    = 1'b1;
            opv_nxt   = 1'b0;
            olast_nxt = 1'b1;
            orec_nxt  = '0;
            oacc_nxt  = 1'b0;
            olive_nxt = occ_r;
            if (occ_r < CNT_W'(CAPACITY) && in_time_value > 32'sd0) begin
              mem_we          = 1'b1;
              mem_waddr       = occ_r[IDX_W-1:0];
              mem_wdata.pos_x = in_pos_x;
              mem_wdata.pos_y = in_pos_y;
              mem_wdata.vel_x = in_vel_x;
              mem_wdata.vel_y = in_vel_y;
              mem_wdata.acc_x = in_acc_x;
              mem_wdata.acc_y = in_acc_y;
              mem_wdata.drag  = in_drag_rate;
              mem_wdata.angle = in_angle;
              mem_wdata.spin  = in_spin;
              mem_wdata.age   = in_start_age;
              mem_wdata.life  = in_time_value;
              occ_nxt         = CNT_W'(occ_r + 1'b1);
              oacc_nxt        = 1'b1;
              olive_nxt       = CNT_W'(occ_r + 1'b1);
            end
          end else begin
            dt_nxt   = in_time_value[31] ? 32'sd0 : in_time_value;
            i_nxt    = '0;
            kept_nxt = '0;
            if (occ_r == '0) begin
              ov_nxt    = 1'b1;
              oacc_nxt  = 1'b0;
              opv_nxt   = 1'b0;
              olast_nxt = 1'b1;
              orec_nxt  = '0;
              olive_nxt = '0;
            end else begin
              state_nxt = ST_RD;
            end
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_LD;
      end
      ST_LD: begin
        w_nxt     = mem_rdata;
        w_nxt.age = age_sum[31] ? AGE_MAX : age_sum[30:0];
        op_nxt    = OP_DT_DRAG;
        ph_nxt    = 1'b0;
        state_nxt = ST_OP;
      end
      ST_OP: begin
        case (op_r)
          OP_DT_DRAG: begin
            mul_a = w_r.drag[31] ? 32'sd0 : w_r.drag;
            mul_b = dt_r;
          end
          OP_INTERP: begin
            // (FRAC[k]-FRAC[k+1])*r >> 12 via a Q16.16 product with r<<4
            mul_a = {15'b0, 17'(frac_hi - frac_lo)};
            mul_b = {16'b0, x_r[11:0], 4'b0};
          end
          OP_FAC: begin
            mul_a = {15'b0, whole_lut(x_r[19:16])};
            mul_b = e_r;
          end
          OP_VX_ACC: begin
            mul_a = w_r.acc_x;
            mul_b = dt_r;
          end
          OP_VY_ACC: begin
            mul_a = w_r.acc_y;
            mul_b = dt_r;
          end
          OP_VX_DAMP: begin
            mul_a = w_r.vel_x;
            mul_b = fac_r;
          end
          OP_VY_DAMP: begin
            mul_a = w_r.vel_y;
            mul_b = fac_r;
          end
          OP_PX: begin
            mul_a = w_r.vel_x;
            mul_b = dt_r;
          end
          OP_PY: begin
            mul_a = w_r.vel_y;
            mul_b = dt_r;
          end
          OP_ANG: begin
            mul_a = w_r.spin;
            mul_b = dt_r;
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          case (op_r)
            OP_DT_DRAG: x_nxt       = mul_q;
            OP_INTERP:  e_nxt       = {15'b0, frac_hi} - mul_q;
            OP_FAC:     fac_nxt     = n_big ? 32'sd0 : mul_q;
            OP_VX_ACC:  w_nxt.vel_x = qadd(w_r.vel_x, mul_q);
            OP_VY_ACC:  w_nxt.vel_y = qadd(w_r.vel_y, mul_q);
            OP_VX_DAMP: w_nxt.vel_x = mul_q;
            OP_VY_DAMP: w_nxt.vel_y = mul_q;
            OP_PX:      w_nxt.pos_x = qadd(w_r.pos_x, mul_q);
            OP_PY:      w_nxt.pos_y = qadd(w_r.pos_y, mul_q);
            OP_ANG:     w_nxt.angle = qadd(w_r.angle, mul_q);
            default:    w_nxt       = w_r;
          endcase
          if (op_r == OP_ANG) begin
            state_nxt = ST_WB;
          end else begin
            op_nxt = op_t'(op_r + 1'b1);
          end
        end
      end
      ST_WB: begin
        if (alive) begin
          mem_we   = 1'b1;
          kept_nxt = kept_inc;
        end
        i_nxt = i_inc;
        if (i_inc == occ_r) begin
          occ_nxt = alive ? kept_inc : kept_r;
          i_nxt   = '0;
          if (!alive && kept_r == '0) begin
            ov_nxt    = 1'b1;
            oacc_nxt  = 1'b0;
            opv_nxt   = 1'b0;
            olast_nxt = 1'b1;
            orec_nxt  = '0;
            olive_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_ORD;
          end
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_ORD: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        ov_nxt    = 1'b1;
        oacc_nxt  = 1'b0;
        opv_nxt   = 1'b1;
        olast_nxt = (i_inc == occ_r);
        orec_nxt  = mem_rdata;
        olive_nxt = occ_r;
        i_nxt     = i_inc;
        state_nxt = (i_inc == occ_r) ? ST_IDLE : ST_ORD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      occ_r   <= '0;
      ov_r    <= 1'b0;
      op_r    <= OP_DT_DRAG;
      ph_r    <= 1'b0;
      i_r     <= '0;
      kept_r  <= '0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      ov_r    <= ov_nxt;
      op_r    <= op_nxt;
      ph_r    <= ph_nxt;
      i_r     <= i_nxt;
      kept_r  <= kept_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dt_r    <= dt_nxt;
    x_r     <= x_nxt;
    e_r     <= e_nxt;
    fac_r   <= fac_nxt;
    w_r     <= w_nxt;
    oacc_r  <= oacc_nxt;
    opv_r   <= opv_nxt;
    olast_r <= olast_nxt;
    orec_r  <= orec_nxt;
    olive_r <= olive_nxt;
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = ov_r;
  assign out_accepted       = oacc_r;
  assign out_particle_valid = opv_r;
  assign out_last           = olast_r;
  assign out_pos_x          = orec_r.pos_x;
  assign out_pos_y          = orec_r.pos_y;
  assign out_vel_x          = orec_r.vel_x;
  assign out_vel_y          = orec_r.vel_y;
  assign out_angle          = orec_r.angle;
  assign out_age            = orec_r.age;
  assign out_live_count     = 7'(olive_r);

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(CAPACITY))
    else $error("pool occupancy above capacity");

  a_emit_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_EMIT) |=> (out_valid && out_last))
    else $error("emit request gave no result");

  a_particle_not_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_particle_valid) |-> (!out_accepted && out_live_count != 7'd0))
    else $error("particle result with bad flags");

  a_kept_le_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB) |-> (kept_r <= i_r))
    else $error("compaction write ahead of read");

endmodule

// File: rtl/ppi_mul.sv
// ----------------------------------------------------------------------------
// ppi_mul: shared Q16.16 multiplier
// Registered 32x32 product, then floor shift by 16 and saturation to 32 bits.
// ----------------------------------------------------------------------------
module ppi_mul (
  input  logic               clk,
  input  logic signed [31:0] op_a,
  input  logic signed [31:0] op_b,
  output logic signed [31:0] q
);

  logic signed [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  // in range when bits 63..47 all agree
  always_comb begin
    if ((&prod_r[63:47]) || !(|prod_r[63:47])) begin
      q = prod_r[47:16];
    end else begin
      q = prod_r[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

endmodule

// File: rtl/ppi_store.sv
// ----------------------------------------------------------------------------
// ppi_store: particle record memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ppi_store
  import ppi_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  rec_t             wdata,
  input  logic [IDX_W-1:0] raddr,
  output rec_t             rdata
);

  rec_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the particle pool integrator
// Directed table then random emit/update requests; every result is compared
// field by field with an in-bench Q16.16 particle pool model.
// ----------------------------------------------------------------------------
module tb
  import ppi_pkg::*;
();

  typedef struct {
    logic               cmd;
    logic signed [31:0] px, py, vx, vy, ax, ay, drag, ang, spin;
    logic [30:0]        age;
    logic signed [31:0] tv;
    logic               has_exp;   // row carries a typed-in expectation
    logic               exp_acc;
    logic [6:0]         exp_cnt;
  } req_t;

  typedef struct {
    logic               acc, pv, last;
    logic signed [31:0] px, py, vx, vy, ang;
    logic [30:0]        age;
    logic [6:0]         cnt;
  } res_t;

  typedef struct {
    logic signed [31:0] px, py, vx, vy, ax, ay, drag, ang, spin, life;
    logic [30:0]        age;
  } part_t;

  logic clk, rst_n, start, busy;
  logic in_command;
  logic signed [31:0] in_pos_x, in_pos_y, in_vel_x, in_vel_y, in_acc_x, in_acc_y;
  logic signed [31:0] in_drag_rate, in_angle, in_spin, in_time_value;
  logic [30:0] in_start_age;
  logic out_valid, out_accepted, out_particle_valid, out_last;
  logic signed [31:0] out_pos_x, out_pos_y, out_vel_x, out_vel_y, out_angle;
  logic [30:0] out_age;
  logic [6:0] out_live_count;

  particle_pool_integrator dut (.*);

  part_t pool[$];
  res_t  expected_q[$];
  int    err_cnt = 0;
  bit    quiet = 0;

  localparam logic [16:0] FRAC_T[17] = '{65536, 61565, 57835, 54331, 51039, 47947,
    45042, 42313, 39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664, 24109};
  localparam logic [16:0] WHOLE_T[12] = '{65536, 24109, 8869, 3263, 1200, 442,
    162, 60, 22, 8, 3, 1};

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sadd(logic signed [31:0] a, logic signed [31:0] b);
    return sat32(longint'(a) + longint'(b));
  endfunction

  // arithmetic shift floors toward minus infinity
  function automatic logic signed [31:0] smul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return sat32(p >>> 16);
  endfunction

  function automatic logic signed [31:0] damp_factor(logic signed [31:0] x);
    logic [31:0] ux;
    int unsigned n, k, r, e;
    longint unsigned w;
    ux = x;
    n = 32'(ux[31:16]);
    k = 32'(ux[15:12]);
    r = 32'(ux[11:0]);
    if (n >= 12) return 0;
    e = FRAC_T[k] - (((FRAC_T[k] - FRAC_T[k+1]) * r) >> 12);
    w = longint'(WHOLE_T[n]) * e;
    return 32'(w >> 16);
  endfunction

  function automatic res_t blank_res(logic acc, logic [6:0] cnt);
    res_t r;
    r = '{default: '0};
    r.acc = acc; r.last = 1'b1; r.cnt = cnt;
    return r;
  endfunction

  task automatic add_expected(input res_t r);
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic predict_pool(input req_t q);
    part_t p;
    part_t kept[$];
    logic signed [31:0] dt, d, fac, v;
    longint age;
    res_t r;
    if (q.cmd == CMD_EMIT) begin
      if (pool.size() < CAPACITY && q.tv > 0) begin
        p = '{px: q.px, py: q.py, vx: q.vx, vy: q.vy, ax: q.ax, ay: q.ay,
              drag: q.drag, ang: q.ang, spin: q.spin, life: q.tv, age: q.age};
        pool.insert(pool.size(), p);
        add_expected(blank_res(1'b1, 7'(pool.size())));
      end else add_expected(blank_res(1'b0, 7'(pool.size())));
      return;
    end
    dt = q.tv < 0 ? 0 : q.tv;
    foreach (pool[i]) begin
      p = pool[i];
      d = p.drag < 0 ? 0 : p.drag;
      fac = damp_factor(smul(d, dt));
      age = longint'(p.age) + longint'(dt);
      p.age = age > 64'h7FFF_FFFF ? AGE_MAX : age[30:0];
      v = smul(sadd(p.vx, smul(p.ax, dt)), fac);
      p.vx = v; p.px = sadd(p.px, smul(v, dt));
      v = smul(sadd(p.vy, smul(p.ay, dt)), fac);
      p.vy = v; p.py = sadd(p.py, smul(v, dt));
      p.ang = sadd(p.ang, smul(p.spin, dt));
      if (longint'(p.age) < longint'(p.life)) kept.insert(kept.size(), p);
    end
    pool = kept;
    if (pool.size() == 0) begin
      add_expected(blank_res(1'b0, 7'd0));
      return;
    end
    foreach (pool[i]) begin
      r = '{acc: 1'b0, pv: 1'b1, last: i == pool.size() - 1, px: pool[i].px,
            py: pool[i].py, vx: pool[i].vx, vy: pool[i].vy, ang: pool[i].ang,
            age: pool[i].age, cnt: 7'(pool.size())};
      add_expected(r);
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_cnt++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

  // result checker
  always @(posedge clk) begin
    res_t w;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) report_mismatch("unexpected result", 0, 0);
      else begin
        w = expected_q.pop_front();
        if (out_accepted !== w.acc) report_mismatch("accepted", out_accepted, w.acc);
        if (out_particle_valid !== w.pv)
          report_mismatch("particle_valid", out_particle_valid, w.pv);
        if (out_last !== w.last) report_mismatch("last", out_last, w.last);
        if (out_pos_x !== w.px) report_mismatch("pos_x", out_pos_x, w.px);
        if (out_pos_y !== w.py) report_mismatch("pos_y", out_pos_y, w.py);
        if (out_vel_x !== w.vx) report_mismatch("vel_x", out_vel_x, w.vx);
        if (out_vel_y !== w.vy) report_mismatch("vel_y", out_vel_y, w.vy);
        if (out_angle !== w.ang) report_mismatch("angle", out_angle, w.ang);
        if (out_age !== w.age) report_mismatch("age", out_age, w.age);
        if (out_live_count !== w.cnt) report_mismatch("live_count", out_live_count, w.cnt);
      end
    end
  end

  function automatic logic signed [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t rnd_emit();
    req_t q;
    q = '{default: '0};
    q.cmd = CMD_EMIT;
    q.px = rnd_word(); q.py = rnd_word(); q.vx = rnd_word(); q.vy = rnd_word();
    q.ax = rnd_word(); q.ay = rnd_word(); q.ang = rnd_word(); q.spin = rnd_word();
    q.drag = $urandom_range(0, 3) == 0 ? rnd_word() : $urandom_range(0, 32'h0003_0000);
    q.age = $urandom_range(0, 7) == 0 ? 31'($urandom) : 31'($urandom_range(0, 32'h0002_0000));
    case ($urandom_range(0, 7))
      0: q.tv = rnd_word();
      1: q.tv = 32'sh7FFF_FFFF;
      default: q.tv = $urandom_range(1, 32'h000A_0000);
    endcase
    return q;
  endfunction

  function automatic req_t rnd_update();
    req_t q;
    q = rnd_emit();
    q.cmd = CMD_UPDATE;
    case ($urandom_range(0, 7))
      0: q.tv = rnd_word();
      1: q.tv = 0;
      default: q.tv = $urandom_range(0, 32'h0000_8000);
    endcase
    return q;
  endfunction

  // start stays high from one request to the next unless an idle gap comes
  task automatic send_request(input req_t q);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= q.cmd;
    in_pos_x <= q.px; in_pos_y <= q.py; in_vel_x <= q.vx; in_vel_y <= q.vy;
    in_acc_x <= q.ax; in_acc_y <= q.ay; in_drag_rate <= q.drag;
    in_angle <= q.ang; in_spin <= q.spin; in_start_age <= q.age;
    in_time_value <= q.tv;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_pool(q);
    if (q.has_exp) begin
      if (expected_q[$].acc !== q.exp_acc) report_mismatch("table accepted", expected_q[$].acc, q.exp_acc);
      if (expected_q[$].cnt !== q.exp_cnt) report_mismatch("table count", expected_q[$].cnt, q.exp_cnt);
    end
  endtask

  req_t stim_table[$];

  task automatic add_row(input req_t q);
    stim_table.insert(stim_table.size(), q);
  endtask

  initial begin
    req_t q;
    int n;
    start = 0; in_command = 0; in_pos_x = 0; in_pos_y = 0; in_vel_x = 0; in_vel_y = 0;
    in_acc_x = 0; in_acc_y = 0; in_drag_rate = 0; in_angle = 0; in_spin = 0;
    in_start_age = 0; in_time_value = 0;
    rst_n = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: update on empty pool, refused lifetimes, extremes, drag cases
    q = '{default: '0}; q.cmd = CMD_UPDATE; q.tv = 32'h0001_0000;
    q.has_exp = 1; q.exp_acc = 0; q.exp_cnt = 0; add_row(q);
    q = '{default: '0}; q.cmd = CMD_EMIT; q.tv = 0;
    q.has_exp = 1; q.exp_acc = 0; q.exp_cnt = 0; add_row(q);
    q.tv = 32'sh8000_0000; add_row(q);
    q = '{default: '0}; q.cmd = CMD_EMIT; q.tv = 32'sh7FFF_FFFF;
    q.px = 32'sh7FFF_FFFF; q.py = 32'sh8000_0000; q.vx = 32'sh7FFF_FFFF;
    q.vy = 32'sh8000_0000; q.ax = 32'sh7FFF_FFFF; q.ay = 32'sh8000_0000;
    q.ang = 32'sh7FFF_FFFF; q.spin = 32'sh7FFF_FFFF; q.age = AGE_MAX - 5;
    q.has_exp = 1; q.exp_acc = 1; q.exp_cnt = 1; add_row(q);
    q = '{default: '0}; q.cmd = CMD_EMIT; q.tv = 32'h0003_0000;
    q.vx = 32'h0001_0000; q.vy = -32'sh0001_0000; q.drag = 32'h0000_8000;
    q.ay = -32'sh0009_8000; q.spin = 32'h0000_C000;
    q.has_exp = 1; q.exp_acc = 1; q.exp_cnt = 2; add_row(q);
    q.drag = 32'sh8000_0000; q.exp_cnt = 3; add_row(q);
    q.drag = 32'sh7FFF_FFFF; q.exp_cnt = 4; add_row(q);
    q.drag = 32'h000B_FFFF; q.exp_cnt = 5; add_row(q);
    q.tv = 1; q.age = 0; q.exp_cnt = 6; add_row(q);
    q = '{default: '0}; q.cmd = CMD_UPDATE; q.tv = 32'sh8000_0000;
    add_row(q);
    q.tv = 32'h0001_0000; add_row(q);
    q.tv = 32'sh7FFF_FFFF; q.px = '1; q.py = '1; q.vx = '1; q.vy = '1; q.ax = '1;
    q.ay = '1; q.drag = '1; q.ang = '1; q.spin = '1; q.age = '1;
    add_row(q);
    foreach (stim_table[i]) send_request(stim_table[i]);

    // fill to capacity and overflow by one
    while (pool.size() < CAPACITY) begin
      q = rnd_emit(); q.tv = 32'h0100_0000; send_request(q);
    end
    q = rnd_emit(); q.tv = 32'h0001_0000; send_request(q);
    q = rnd_update(); q.tv = 32'h0000_1000; send_request(q);
    // hold off until all results are in
    start <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    q = rnd_update(); q.tv = 32'h7FFF_FFFF; send_request(q);

    // random: a mix of emits and updates, about two emits per update
    n = 0;
    while (n < 130) begin
      if (n > 110) quiet = 1;
      if ($urandom_range(0, 2) != 0) q = rnd_emit();
      else q = rnd_update();
      send_request(q);
      n++;
    end
    start <= 1'b0;

    n = 0;
    while (expected_q.size() != 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
    repeat (50) @(posedge clk);
    if (err_cnt == 0 && expected_q.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
